// ===== design/prh_pkg.sv =====
// Shared types and constants for the PC range profile histogram.
// No dependencies; imported by pc_range_profile_histogram.
`default_nettype none

package prh_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int NREG_W      = 5;
	localparam int PC_W        = 16;
	localparam int CNT_W       = 32;
	localparam int LOST_W      = 16;
	localparam int OP_W        = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGIONS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CNT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== design/prh_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Per-entry valid bits make never-written entries read as zero after reset.
`default_nettype none

module prh_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/pc_range_profile_histogram.sv =====
// PC range profile histogram. Every accepted item gives exactly one result beat.
// A sample (enabled) bumps the tick total, then walks the region bounds RAM one
// entry per cycle from index 0; the first region whose inclusive start..end holds
// the PC gets its hit counter read, incremented and written back. No match
// records the PC as lost and bumps the lost total. Write items load one region's
// bounds and report its count; read items report its count. Items are handled
// one at a time: a sample that matches region i checks regions 0 through i, an
// unmatched sample the number of regions searched (num_regions, clamped to 16),
// so none when num_regions is 0; a write or read goes through a counter read,
// a disabled sample or unused opcode straight to its result. The time is set
// by the one-entry-per-cycle scan through the bounds RAM read port. The result
// sits in an output register, so a held result does not stall work on the
// next item until that item's result is ready. No clearing pass after reset.
// Depends on prh_pkg and prh_ram.
`default_nettype none

module pc_range_profile_histogram (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [prh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [prh_pkg::CFG_DATA_W-1:0] cfg_data,
	// input item channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [prh_pkg::OP_W-1:0]      operation,
	input  wire logic [prh_pkg::PC_W-1:0]      pc_sample,
	input  wire logic [prh_pkg::IDX_W-1:0]     region_index,
	input  wire logic [prh_pkg::PC_W-1:0]      region_start,
	input  wire logic [prh_pkg::PC_W-1:0]      region_end,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               hit,
	output logic      [prh_pkg::IDX_W-1:0]     matched_region,
	output logic      [prh_pkg::CNT_W-1:0]     count_value,
	output logic      [prh_pkg::CNT_W-1:0]     tick_total,
	output logic      [prh_pkg::PC_W-1:0]      lost_pc,
	output logic      [prh_pkg::LOST_W-1:0]    lost_total
);

	import prh_pkg::*;

	// config registers
	logic              enable_q;
	logic [NREG_W-1:0] num_regions_q;

	// FSM and latched item
	state_t            state_q, state_d;
	logic [OP_W-1:0]   op_q;
	logic [PC_W-1:0]   pc_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  scan_idx_q;

	// scalar profile state
	logic [CNT_W-1:0]  tick_q;
	logic [PC_W-1:0]   lost_pc_q;
	logic [LOST_W-1:0] lost_cnt_q;

	// pending result
	logic              res_hit_q;
	logic [IDX_W-1:0]  res_region_q;
	logic [CNT_W-1:0]  res_count_q;

	// output register
	logic              out_valid_q;
	logic              out_hit_q;
	logic [IDX_W-1:0]  out_region_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [CNT_W-1:0]  out_tick_q;
	logic [PC_W-1:0]   out_lost_pc_q;
	logic [LOST_W-1:0] out_lost_cnt_q;

	// RAM ports
	logic              bnd_we;
	logic [IDX_W-1:0]  bnd_raddr;
	logic [2*PC_W-1:0] bnd_rdata;
	logic              cnt_we;
	logic [IDX_W-1:0]  cnt_raddr;
	logic [CNT_W-1:0]  cnt_rdata;
	logic [CNT_W-1:0]  cnt_inc;

	// control strobes
	logic              accept;
	logic              tick_inc;
	logic              lost_upd;
	logic              res_zero;
	logic              res_hit_ld;
	logic              res_read_ld;
	logic              scan_clr;
	logic              scan_adv;
	logic              out_load;

	logic [NREG_W-1:0] limit;
	logic              out_free;
	logic              bnd_match;
	logic              scan_last;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// regions searched, clamped to table depth
	assign limit = (num_regions_q > NREG_W'(MAX_REGIONS)) ? NREG_W'(MAX_REGIONS)
	                                                      : num_regions_q;

	// bounds word: start in the upper half, end in the lower half
	assign bnd_match = (pc_q >= bnd_rdata[2*PC_W-1:PC_W]) && (pc_q <= bnd_rdata[PC_W-1:0]);
	assign scan_last = (({1'b0, scan_idx_q} + NREG_W'(1)) >= limit);
	assign cnt_inc   = cnt_rdata + CNT_W'(1);

	prh_ram #(
		.DATA_W (2*PC_W),
		.ADDR_W (IDX_W)
	) u_bnd_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (bnd_we),
		.waddr  (region_index),
		.wdata  ({region_start, region_end}),
		.raddr  (bnd_raddr),
		.rdata  (bnd_rdata)
	);

	prh_ram #(
		.DATA_W (CNT_W),
		.ADDR_W (IDX_W)
	) u_cnt_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cnt_we),
		.waddr  (scan_idx_q),
		.wdata  (cnt_inc),
		.raddr  (cnt_raddr),
		.rdata  (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d     = state_q;
		bnd_we      = 1'b0;
		bnd_raddr   = '0;
		cnt_we      = 1'b0;
		cnt_raddr   = scan_idx_q;
		tick_inc    = 1'b0;
		lost_upd    = 1'b0;
		res_zero    = 1'b0;
		res_hit_ld  = 1'b0;
		res_read_ld = 1'b0;
		scan_clr    = 1'b0;
		scan_adv    = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cnt_raddr = region_index;
				if (in_valid) begin
					case (operation)
						OP_SAMPLE: begin
							if (enable_q) begin
								tick_inc = 1'b1;
								scan_clr = 1'b1;
								if (limit == '0) begin
									lost_upd = 1'b1;
									res_zero = 1'b1;
									state_d  = ST_DONE;
								end else begin
									state_d = ST_SCAN;
								end
							end else begin
								res_zero = 1'b1;
								state_d  = ST_DONE;
							end
						end
						OP_WRITE: begin
							bnd_we  = 1'b1;
							state_d = ST_CNT;
						end
						OP_READ: begin
							state_d = ST_CNT;
						end
						default: begin
							res_zero = 1'b1;
							state_d  = ST_DONE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// bnd_rdata holds entry scan_idx_q
				if (bnd_match) begin
					state_d = ST_CNT;
				end else if (scan_last) begin
					lost_upd = 1'b1;
					res_zero = 1'b1;
					state_d  = ST_DONE;
				end else begin
					bnd_raddr = scan_idx_q + IDX_W'(1);
					scan_adv  = 1'b1;
				end
			end
			ST_CNT: begin
				if (op_q == OP_SAMPLE) begin
					cnt_we     = 1'b1;
					res_hit_ld = 1'b1;
				end else begin
					res_read_ld = 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// config, counters and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			num_regions_q <= '0;
			tick_q        <= '0;
			lost_pc_q     <= '0;
			lost_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
			scan_idx_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ENABLE:      enable_q      <= cfg_data[0];
					CFG_NUM_REGIONS: num_regions_q <= cfg_data[NREG_W-1:0];
					default: ;
				endcase
			end
			if (tick_inc) begin
				tick_q <= tick_q + CNT_W'(1);
			end
			if (lost_upd) begin
				// empty scan is decided at accept, before pc_q holds the sample
				lost_pc_q  <= (state_q == ST_IDLE) ? pc_sample : pc_q;
				lost_cnt_q <= lost_cnt_q + LOST_W'(1);
			end
			if (scan_clr) begin
				scan_idx_q <= '0;
			end else if (scan_adv) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// latched item, pending result, output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			pc_q  <= pc_sample;
			idx_q <= region_index;
		end
		if (res_zero) begin
			res_hit_q    <= 1'b0;
			res_region_q <= '0;
			res_count_q  <= '0;
		end else if (res_hit_ld) begin
			res_hit_q    <= 1'b1;
			res_region_q <= scan_idx_q;
			res_count_q  <= cnt_inc;
		end else if (res_read_ld) begin
			res_hit_q    <= 1'b0;
			res_region_q <= idx_q;
			res_count_q  <= cnt_rdata;
		end
		if (out_load) begin
			out_hit_q      <= res_hit_q;
			out_region_q   <= res_region_q;
			out_count_q    <= res_count_q;
			out_tick_q     <= tick_q;
			out_lost_pc_q  <= lost_pc_q;
			out_lost_cnt_q <= lost_cnt_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = out_hit_q;
	assign matched_region = out_region_q;
	assign count_value    = out_count_q;
	assign tick_total     = out_tick_q;
	assign lost_pc        = out_lost_pc_q;
	assign lost_total     = out_lost_cnt_q;

endmodule

`default_nettype wire
